>>> rtl/fpl_pkg.sv
// ----------------------------------------------------------------------------
// fpl_pkg: shared types and constants of the ladder low-pass filter
// Fixed-point formats, the pole limit and the inter-cell link record.
// ----------------------------------------------------------------------------
`default_nettype none

package fpl_pkg;

  // Internal format: signed, 16 fraction bits, 18 bits wide.
  localparam int Q_WIDTH     = 18;
  localparam int FRAC        = 16;
  localparam int GAIN_WIDTH  = 17;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 18;

  // Register indices of the configuration port.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POLE_COEFF    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEEDBACK_GAIN = 2'd1;

  // 0.65 and 0.95 in the internal format.
  localparam logic signed [16:0] K_IN_SCALE = 17'sd42598;
  localparam logic signed [21:0] K_LIMIT    = 22'sd62259;

  localparam logic signed [Q_WIDTH-1:0] Q_MAX = 18'sd131071;
  localparam logic signed [Q_WIDTH-1:0] Q_MIN = -18'sd131072;

  typedef logic signed [Q_WIDTH-1:0] q_t;
  typedef logic [GAIN_WIDTH-1:0]     gain_t;

  // Value handed from one cell to the next.
  typedef struct packed {
    logic valid;
    q_t   value;
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUB,
    ST_CHAIN,
    ST_FEED
  } state_t;

  // Limits a wide intermediate to plus or minus 0.95.
  function automatic q_t clamp_pole(input logic signed [21:0] v);
    q_t r;
    if (v > K_LIMIT) begin
      r = Q_WIDTH'(K_LIMIT);
    end else if (v < -K_LIMIT) begin
      r = Q_WIDTH'(-K_LIMIT);
    end else begin
      r = Q_WIDTH'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fpl_cell.sv
// ----------------------------------------------------------------------------
// fpl_cell: one pole of the ladder
// Holds its pole state. Takes a value from the previous cell, registers the
// product, then clamps, stores and passes on the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fpl_cell (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire fpl_pkg::q_t  pole_coeff,
  input  wire fpl_pkg::link_t link_in,
  output fpl_pkg::link_t    link_out
);
  import fpl_pkg::*;

  q_t                  store;
  logic                busy;
  q_t                  v_hold;
  logic signed [36:0]  prod;
  logic signed [36:0]  prod_next;
  logic signed [36:0]  prod_rnd;
  logic signed [18:0]  diff;
  logic signed [20:0]  prod_q;
  q_t                  store_next;
  q_t                  pass_value;
  logic                out_valid;
  q_t                  out_value;

  assign diff      = 19'(link_in.value) - 19'(store);
  assign prod_next = diff * 37'(pole_coeff);
  assign prod_rnd  = prod + 37'sd32768;
  assign prod_q    = 21'(prod_rnd >>> FRAC);

  assign store_next = clamp_pole(22'(v_hold) + 22'(prod_q));
  assign pass_value = clamp_pole(22'(store_next) + 22'(store));

  always_ff @(posedge clk) begin
    if (rst) begin
      store     <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy      <= link_in.valid;
      out_valid <= busy;
      if (busy) begin
        store <= store_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.valid) begin
      v_hold <= link_in.value;
      prod   <= prod_next;
    end
    if (busy) begin
      out_value <= pass_value;
    end
  end

  assign link_out.valid = out_valid;
  assign link_out.value = out_value;

endmodule

`default_nettype wire

>>> rtl/four_pole_ladder_lowpass.sv
// ----------------------------------------------------------------------------
// four_pole_ladder_lowpass: resonant four-pole ladder low-pass filter
// Scales each sample, subtracts the resonance feedback and runs the value
// down a chain of pole cells; the last cell's output is the result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries sample_in; a request is taken
//   at a clock edge where in_valid is high and in_stall is low. The output
//   channel out_valid/out_stall carries sample_out in the same way.
//   The configuration channel cfg_valid/cfg_ready writes pole_coeff
//   (index 0) or feedback_gain (index 1); other indices are ignored.
//   cfg_ready is always high; write only while the filter is idle.
//   One sample is processed at a time: in_stall stays high while a sample
//   runs down the chain, where each cell multiplies, then clamps and
//   stores, and until its feedback product is ready for the next sample's
//   subtraction.
//   The next sample is accepted while a finished result still waits; if
//   out_stall is held, that sample is stopped just before the output
//   register and the feedback register, and input stalls until it moves.
//   Reset (rst, synchronous) clears the pole state, the feedback value and
//   both coefficients, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module four_pole_ladder_lowpass #(
  parameter int NUM_POLES    = 4,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic signed [SAMPLE_WIDTH-1:0]       sample_out,
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [fpl_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [fpl_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import fpl_pkg::*;

  localparam int IO_FRAC = SAMPLE_WIDTH - 1;
  localparam int UP      = (IO_FRAC < FRAC) ? FRAC - IO_FRAC : 0;
  localparam int DOWN    = (IO_FRAC > FRAC) ? IO_FRAC - FRAC : 0;

  state_t state;
  state_t state_next;

  q_t    pole_coeff;
  gain_t feedback_gain;
  q_t    feedback_value;

  q_t                 x_q;
  logic signed [34:0] prod_in;
  logic signed [34:0] prod_in_rnd;
  logic signed [18:0] scaled;
  logic signed [19:0] diff_sum;
  q_t                 v_first;

  q_t                 res_v;
  logic signed [35:0] fb_prod;
  logic signed [35:0] fb_rnd;
  logic signed [19:0] fb_q;
  q_t                 fb_sat;
  logic signed [SAMPLE_WIDTH-1:0] out_conv;

  link_t              link [NUM_POLES+1];
  logic [NUM_POLES:0] chain_valid;

  logic in_take;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Input to the internal format.
  generate
    if (DOWN > 0) begin : g_in_down
      logic signed [SAMPLE_WIDTH:0] x_ext;
      assign x_ext = (SAMPLE_WIDTH+1)'(sample_in) + (SAMPLE_WIDTH+1)'(2 ** (DOWN - 1));
      assign x_q   = Q_WIDTH'(x_ext >>> DOWN);
    end else begin : g_in_up
      assign x_q = Q_WIDTH'(sample_in) <<< UP;
    end
  endgenerate

  // Result back to the sample format, rounding half up when bits are dropped.
  generate
    if (UP > 0) begin : g_out_down
      logic signed [Q_WIDTH:0] r_ext;
      assign r_ext    = (Q_WIDTH+1)'(res_v) + (Q_WIDTH+1)'(2 ** (UP - 1));
      assign out_conv = SAMPLE_WIDTH'(r_ext >>> UP);
    end else begin : g_out_up
      assign out_conv = SAMPLE_WIDTH'(res_v) <<< DOWN;
    end
  endgenerate

  assign prod_in_rnd = prod_in + 35'sd32768;
  assign scaled      = 19'(prod_in_rnd >>> FRAC);
  assign diff_sum    = 20'(scaled) - 20'(feedback_value) + 20'sd2;
  assign v_first     = Q_WIDTH'(diff_sum >>> 2);

  assign fb_rnd = fb_prod + 36'sd32768;
  assign fb_q   = 20'(fb_rnd >>> FRAC);
  always_comb begin
    if (fb_q > 20'(Q_MAX)) begin
      fb_sat = Q_MAX;
    end else if (fb_q < 20'(Q_MIN)) begin
      fb_sat = Q_MIN;
    end else begin
      fb_sat = Q_WIDTH'(fb_q);
    end
  end

  assign link[0].valid = (state == ST_SUB);
  assign link[0].value = v_first;

  generate
    for (genvar i = 0; i < NUM_POLES; i++) begin : g_cell
      fpl_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .pole_coeff (pole_coeff),
        .link_in    (link[i]),
        .link_out   (link[i+1])
      );
    end
    for (genvar j = 0; j <= NUM_POLES; j++) begin : g_valid
      assign chain_valid[j] = link[j].valid;
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_SUB;
        end
      end
      ST_SUB: begin
        state_next = ST_CHAIN;
      end
      ST_CHAIN: begin
        if (link[NUM_POLES].valid) begin
          state_next = ST_FEED;
        end
      end
      ST_FEED: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pole_coeff     <= '0;
      feedback_gain  <= '0;
      feedback_value <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_POLE_COEFF:    pole_coeff    <= Q_WIDTH'(cfg_data);
          REG_FEEDBACK_GAIN: feedback_gain <= GAIN_WIDTH'(cfg_data);
          default: ;
        endcase
      end
      if (state == ST_FEED && out_free) begin
        feedback_value <= fb_sat;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      prod_in <= x_q * 35'(K_IN_SCALE);
    end
    if (state == ST_CHAIN && link[NUM_POLES].valid) begin
      res_v   <= link[NUM_POLES].value;
      fb_prod <= 36'(link[NUM_POLES].value) * 36'({1'b0, feedback_gain});
    end
    if (state == ST_FEED && out_free) begin
      sample_out <= out_conv;
    end
  end

  // At most one value travels along the chain at a time.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one value in the pole chain");

  // Nothing is in the chain while the filter waits for a request.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (chain_valid == '0))
    else $error("pole chain busy while idle");

  // A new result is only shown after the feedback register was updated.
  a_out_from_feed: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FEED))
    else $error("result shown outside the feedback step");

  // The last cell only reports while a request is being worked on.
  a_chain_end: assert property (@(posedge clk) disable iff (rst)
    link[NUM_POLES].valid |-> (state == ST_CHAIN))
    else $error("pole chain output outside the chain phase");

endmodule

`default_nettype wire

>>> verif/four_pole_ladder_lowpass_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_pole_ladder_lowpass_test: self-checking bench for the ladder filter
// Sends samples through the filter under a range of cutoff and resonance
// settings and compares every result with a bit-exact fixed-point
// prediction, with random gaps on both channels and a long output hold-off.
// ----------------------------------------------------------------------------

module four_pole_ladder_lowpass_test;
  import fpl_pkg::*;

  localparam int NUM_POLES      = 4;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int SETTLE_CYCLES  = 2 * NUM_POLES + 3 + 8;
  localparam int LIMIT_CYCLES   = 400000;
  localparam int HOLD_OFF_CYCLES = 300;

  // Indices that the filter has no register behind.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic out_valid;
  logic out_stall;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  // Shadow copy of the filter's registers and memory.
  q_t    cutoff_coeff;
  gain_t resonance_gain;
  q_t    pole_state [NUM_POLES];
  q_t    feedback_state;

  logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];

  int  error_count = 0;
  int  cycle_count = 0;
  logic sender_gaps_on = 1'b0;
  logic receiver_gaps_on = 1'b0;
  logic hold_request = 1'b0;

  four_pole_ladder_lowpass #(
    .NUM_POLES   (NUM_POLES),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Product of two Q16 values, rounded to nearest with ties upwards.
  function automatic longint round_product(input longint a, input longint b);
    return (a * b + 32768) >>> FRAC;
  endfunction

  function automatic longint limit_pole(input longint v);
    longint lim;
    lim = longint'(K_LIMIT);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advances the shadow filter by one sample and returns the output sample.
  function automatic logic signed [SAMPLE_WIDTH-1:0] filter_sample(
    input logic signed [SAMPLE_WIDTH-1:0] smp
  );
    longint acc, old, settled, shown;
    acc = longint'(smp) * 2;
    acc = round_product(acc, longint'(K_IN_SCALE));
    acc = (acc - longint'(feedback_state) + 2) >>> 2;
    for (int i = 0; i < NUM_POLES; i++) begin
      old = longint'(pole_state[i]);
      settled = limit_pole(acc + round_product(longint'(cutoff_coeff), acc - old));
      pole_state[i] = q_t'(settled);
      acc = limit_pole(settled + old);
    end
    shown = (acc + 1) >>> 1;
    settled = round_product(acc, longint'(resonance_gain));
    if (settled > longint'(Q_MAX)) settled = longint'(Q_MAX);
    if (settled < longint'(Q_MIN)) settled = longint'(Q_MIN);
    feedback_state = q_t'(settled);
    return shown[SAMPLE_WIDTH-1:0];
  endfunction

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (receiver_gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out: expected none, actual %0d", sample_out);
        error_count++;
      end else if (sample_out !== expected_samples[0]) begin
        $error("sample_out: expected %0d, actual %0d", expected_samples[0], sample_out);
        error_count++;
        void'(expected_samples.pop_front());
      end else begin
        void'(expected_samples.pop_front());
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] smp);
    @(negedge clk);
    if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= smp;
    do @(posedge clk); while (in_stall);
    expected_samples.push_back(filter_sample(smp));
  endtask

  task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                input logic [CFG_DATA_WIDTH-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_POLE_COEFF: begin
        cutoff_coeff = q_t'(data);
      end
      REG_FEEDBACK_GAIN: begin
        resonance_gain = data[GAIN_WIDTH-1:0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drops the input request and waits until every result is out and the
  // feedback product of the last sample has had time to settle.
  task automatic settle_filter();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    settle_filter();
  endtask

  task automatic test_register_extremes();
    // Largest cutoff and a resonance above one.
    write_register(REG_POLE_COEFF, 18'h1FFFF);
    write_register(REG_FEEDBACK_GAIN, 18'h1FFFF);
    write_register(REG_SPARE_A, 18'h2AAAA);
    write_register(REG_SPARE_B, 18'h15555);
    repeat (4) send_sample(16'sh7FFF);
    repeat (4) send_sample(16'sh8000);
    settle_filter();
    // Most negative cutoff; the top data bit of the gain must be dropped.
    write_register(REG_POLE_COEFF, 18'h20000);
    write_register(REG_FEEDBACK_GAIN, 18'h30000);
    repeat (3) send_sample(16'sh8000);
    repeat (3) send_sample(16'sh7FFF);
    settle_filter();
    write_register(REG_POLE_COEFF, 18'h08000);
    write_register(REG_FEEDBACK_GAIN, 18'h00000);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(16'sh0001);
    send_sample(16'shFFFE);
    settle_filter();
  endtask

  task automatic random_settings();
    if ($urandom_range(0, 1) == 0) begin
      write_register(REG_POLE_COEFF, 18'($urandom_range(0, 80000)));
    end else begin
      write_register(REG_POLE_COEFF, 18'($urandom));
    end
    write_register(REG_FEEDBACK_GAIN, 18'($urandom_range(0, 262143)));
  endtask

  task automatic test_random_settings();
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic signed [SAMPLE_WIDTH-1:0] level;
    level = '0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_register(REG_POLE_COEFF, 18'h1FFFF);
          write_register(REG_FEEDBACK_GAIN, 18'h10000);
        end
        1: begin
          write_register(REG_POLE_COEFF, 18'h20000);
          write_register(REG_FEEDBACK_GAIN, 18'h00000);
        end
        default: begin
          random_settings();
        end
      endcase
      sender_gaps_on   = ($urandom_range(0, 3) != 0);
      receiver_gaps_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 70; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: smp = SAMPLE_WIDTH'($urandom);
          3, 4: smp = SAMPLE_WIDTH'(int'($urandom_range(0, 4000)) - 2000);
          5, 6, 7: smp = level;
          8: begin
            level = SAMPLE_WIDTH'($urandom);
            smp = level;
          end
          default: smp = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        endcase
        send_sample(smp);
      end
      settle_filter();
    end
  endtask

  // The output is held off for a long stretch while samples keep coming,
  // so the filter fills up and must stall its input request.
  task automatic test_output_hold_off();
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b0;
    random_settings();
    hold_request = 1'b1;
    repeat (30) send_sample(SAMPLE_WIDTH'($urandom));
    settle_filter();
  endtask

  task automatic test_full_rate();
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b0;
    random_settings();
    repeat (120) send_sample(SAMPLE_WIDTH'($urandom));
    settle_filter();
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    sample_in      = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    cutoff_coeff   = '0;
    resonance_gain = '0;
    feedback_state = '0;
    for (int i = 0; i < NUM_POLES; i++) pole_state[i] = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_register_extremes();
    test_random_settings();
    test_output_hold_off();
    test_full_rate();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
